// File: rtl/omb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility block package
// Widths, sideband types and entry tables shared by the pipeline modules.
// ----------------------------------------------------------------------------
package omb_pkg;

   localparam int POS_W  = 32;
   localparam int MAG_W  = 33;
   localparam int NM_W   = 30;
   localparam int SP_W   = 62;
   localparam int ROOT_W = 31;
   localparam int INV_W  = 33;
   localparam int U_W    = 32;
   localparam int T_W    = 62;
   localparam int T30_W  = 32;
   localparam int P_W    = 65;
   localparam int ENT_W  = 32;
   localparam int NUM_ENT = 6;

   localparam logic [2:0] ADDR_NEAR_LIMIT = 3'd0;

   localparam logic [1:0] ROW_I [NUM_ENT] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] COL_J [NUM_ENT] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   typedef struct packed {
      logic [2:0][NM_W-1:0] nm;
      logic [2:0]           neg;
      logic signed [5:0]    e;
      logic                 same;
      logic                 near;
   } side_type;

   typedef struct packed {
      logic [NUM_ENT-1:0][ENT_W-1:0] m;
      logic                          too_near;
      logic                          overflowed;
   } res_type;

endpackage

// File: rtl/omb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility front end
// Forms the separation, the near test, the normalizing exponent and the
// normalized squared distance over six register stages.
// ----------------------------------------------------------------------------
module omb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [omb_pkg::POS_W-1:0] a_x,
   input  logic signed [omb_pkg::POS_W-1:0] a_y,
   input  logic signed [omb_pkg::POS_W-1:0] a_z,
   input  logic signed [omb_pkg::POS_W-1:0] b_x,
   input  logic signed [omb_pkg::POS_W-1:0] b_y,
   input  logic signed [omb_pkg::POS_W-1:0] b_z,
   input  logic                           same_particle,
   input  logic [31:0]                    near_limit_sq,
   output logic                           out_valid,
   output logic [omb_pkg::SP_W-1:0]       sp,
   output omb_pkg::side_type              side
);

   localparam int MW = omb_pkg::MAG_W;
   localparam int NW = omb_pkg::NM_W;

   logic [2:0][MW-1:0] s1_mag_in, s1_mag_ff;
   logic [2:0]         s1_neg_in, s1_neg_ff;
   logic               s1_same_ff, s1_vld_ff;

   logic [MW-1:0]      s2_m_in, s2_m_ff;
   logic [2:0][31:0]   s2_sq_in, s2_sq_ff;
   logic               s2_small_in, s2_small_ff;
   logic [2:0][MW-1:0] s2_mag_ff;
   logic [2:0]         s2_neg_ff;
   logic               s2_same_ff, s2_vld_ff;

   logic [33:0]        s3_sum;
   logic [5:0]         s3_pos;
   logic               s3_near_in, s3_near_ff;
   logic signed [5:0]  s3_e_in, s3_e_ff;
   logic [2:0][MW-1:0] s3_mag_ff;
   logic [2:0]         s3_neg_ff;
   logic               s3_same_ff, s3_vld_ff;

   logic [5:0]         s4_ne;
   logic [2:0][NW-1:0] s4_nm_in;
   omb_pkg::side_type  s4_side_ff;
   logic               s4_vld_ff;

   logic [2:0][2*NW-1:0] s5_sq_in, s5_sq_ff;
   omb_pkg::side_type  s5_side_ff;
   logic               s5_vld_ff;

   logic [omb_pkg::SP_W-1:0] s6_sp_in, s6_sp_ff;
   omb_pkg::side_type  s6_side_ff;
   logic               s6_vld_ff;

   logic signed [MW-1:0] d_x, d_y, d_z;

   always_comb begin
      d_x = {a_x[31], a_x} - {b_x[31], b_x};
      d_y = {a_y[31], a_y} - {b_y[31], b_y};
      d_z = {a_z[31], a_z} - {b_z[31], b_z};
      s1_neg_in = {d_z[MW-1], d_y[MW-1], d_x[MW-1]};
      s1_mag_in[0] = d_x[MW-1] ? MW'(-d_x) : MW'(d_x);
      s1_mag_in[1] = d_y[MW-1] ? MW'(-d_y) : MW'(d_y);
      s1_mag_in[2] = d_z[MW-1] ? MW'(-d_z) : MW'(d_z);
   end

   always_comb begin
      s2_m_in = s1_mag_ff[0];
      if (s1_mag_ff[1] > s2_m_in) begin
         s2_m_in = s1_mag_ff[1];
      end
      if (s1_mag_ff[2] > s2_m_in) begin
         s2_m_in = s1_mag_ff[2];
      end
      s2_small_in = (s2_m_in[MW-1:16] == '0);
      for (int k = 0; k < 3; k++) begin
         s2_sq_in[k] = 32'(s1_mag_ff[k][15:0]) * 32'(s1_mag_ff[k][15:0]);
      end
   end

   always_comb begin
      s3_sum = 34'(s2_sq_ff[0]) + 34'(s2_sq_ff[1]) + 34'(s2_sq_ff[2]);
      s3_near_in = s2_small_ff && (s3_sum <= 34'(near_limit_sq));
      s3_pos = '0;
      for (int i = 0; i < MW; i++) begin
         if (s2_m_ff[i]) begin
            s3_pos = 6'(i);
         end
      end
      s3_e_in = $signed(6'd29 - s3_pos);
   end

   always_comb begin
      s4_ne = 6'(-s3_e_ff);
      for (int k = 0; k < 3; k++) begin
         if (!s3_e_ff[5]) begin
            s4_nm_in[k] = NW'(64'(s3_mag_ff[k]) << s3_e_ff[4:0]);
         end else begin
            s4_nm_in[k] = NW'(s3_mag_ff[k] >> s4_ne[1:0]);
         end
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s5_sq_in[k] = (2*NW)'(s4_side_ff.nm[k]) * (2*NW)'(s4_side_ff.nm[k]);
      end
      s6_sp_in = omb_pkg::SP_W'(s5_sq_ff[0]) + omb_pkg::SP_W'(s5_sq_ff[1])
               + omb_pkg::SP_W'(s5_sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= in_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff  <= s1_mag_in;
         s1_neg_ff  <= s1_neg_in;
         s1_same_ff <= same_particle;

         s2_m_ff     <= s2_m_in;
         s2_sq_ff    <= s2_sq_in;
         s2_small_ff <= s2_small_in;
         s2_mag_ff   <= s1_mag_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_same_ff  <= s1_same_ff;

         s3_near_ff <= s3_near_in;
         s3_e_ff    <= s3_e_in;
         s3_mag_ff  <= s2_mag_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_same_ff <= s2_same_ff;

         s4_side_ff.nm   <= s4_nm_in;
         s4_side_ff.neg  <= s3_neg_ff;
         s4_side_ff.e    <= s3_e_ff;
         s4_side_ff.same <= s3_same_ff;
         s4_side_ff.near <= s3_near_ff;

         s5_sq_ff   <= s5_sq_in;
         s5_side_ff <= s4_side_ff;

         s6_sp_ff   <= s6_sp_in;
         s6_side_ff <= s5_side_ff;
      end
   end

   assign out_valid = s6_vld_ff;
   assign sp        = s6_sp_ff;
   assign side      = s6_side_ff;

endmodule

// File: rtl/omb_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility square root
// Floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module omb_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [omb_pkg::SP_W-1:0]   sp,
   input  omb_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [omb_pkg::ROOT_W-1:0] root,
   output omb_pkg::side_type          out_side
);

   localparam int W     = omb_pkg::SP_W + 1;
   localparam int STEPS = (omb_pkg::SP_W + 2) / 2;

   logic [W-1:0]      val_ff  [STEPS+1];
   logic [W-1:0]      res_ff  [STEPS+1];
   omb_pkg::side_type side_ff [STEPS+1];
   logic              vld_ff  [STEPS+1];

   always_comb begin
      val_ff[0]  = W'(sp);
      res_ff[0]  = '0;
      side_ff[0] = in_side;
      vld_ff[0]  = in_valid;
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (W - 1 - 2*k);
      logic [W-1:0] trial;
      logic [W-1:0] val_in, res_in;

      always_comb begin
         trial = res_ff[k] + BIT;
         if (val_ff[k] >= trial) begin
            val_in = val_ff[k] - trial;
            res_in = (res_ff[k] >> 1) + BIT;
         end else begin
            val_in = val_ff[k];
            res_in = res_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[k+1]  <= val_in;
            res_ff[k+1]  <= res_in;
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign root      = res_ff[STEPS][omb_pkg::ROOT_W-1:0];
   assign out_side  = side_ff[STEPS];

endmodule

// File: rtl/omb_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility reciprocal
// Restoring division of 2^61 by the root, one quotient bit per stage.
// ----------------------------------------------------------------------------
module omb_recip (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [omb_pkg::ROOT_W-1:0] root,
   input  omb_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [omb_pkg::INV_W-1:0]  inv,
   output omb_pkg::side_type          out_side
);

   localparam int QW = omb_pkg::INV_W;
   localparam int RW = omb_pkg::ROOT_W + 2;

   logic [RW-1:0]             rem_ff  [QW+1];
   logic [QW-1:0]             quo_ff  [QW+1];
   logic [omb_pkg::ROOT_W-1:0] div_ff [QW+1];
   omb_pkg::side_type         side_ff [QW+1];
   logic                      vld_ff  [QW+1];

   always_comb begin
      rem_ff[0]  = RW'(1) << (61 - QW);
      quo_ff[0]  = '0;
      div_ff[0]  = root;
      side_ff[0] = in_side;
      vld_ff[0]  = in_valid;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [RW-1:0] shifted;
      logic [RW-1:0] rem_in;
      logic          bit_in;

      always_comb begin
         shifted = {rem_ff[k][RW-2:0], 1'b0};
         bit_in  = (shifted >= RW'(div_ff[k]));
         rem_in  = bit_in ? shifted - RW'(div_ff[k]) : shifted;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= rem_in;
            quo_ff[k+1]  <= {quo_ff[k][QW-2:0], bit_in};
            div_ff[k+1]  <= div_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = vld_ff[QW];
   assign inv       = quo_ff[QW];
   assign out_side  = side_ff[QW];

endmodule

// File: rtl/omb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility back end
// Scales the unit direction into the six tensor entries, saturates them and
// selects the identity or zero block, over six register stages.
// ----------------------------------------------------------------------------
module omb_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [omb_pkg::INV_W-1:0] inv,
   input  omb_pkg::side_type         in_side,
   output logic                      out_valid,
   output omb_pkg::res_type          result
);

   localparam int NE = omb_pkg::NUM_ENT;
   localparam int IW = omb_pkg::INV_W;
   localparam int PW = omb_pkg::P_W;

   logic [2:0][omb_pkg::U_W-1:0] p1_u_in, p1_u_ff;
   logic [IW-1:0]                p1_inv_ff;
   omb_pkg::side_type            p1_side_ff;
   logic                         p1_vld_ff;

   logic [NE-1:0][omb_pkg::T_W-1:0] p2_t_in, p2_t_ff;
   logic [IW-1:0]                p2_inv_ff;
   omb_pkg::side_type            p2_side_ff;
   logic                         p2_vld_ff;

   logic [NE-1:0][omb_pkg::T_W-1:0] p3_tt;
   logic [NE-1:0][omb_pkg::T30_W-1:0] p3_t30_in, p3_t30_ff;
   logic [NE-1:0]                p3_sgn_in, p3_sgn_ff;
   logic [IW-1:0]                p3_inv_ff;
   omb_pkg::side_type            p3_side_ff;
   logic                         p3_vld_ff;

   logic [NE-1:0][PW-1:0]        p4_p_in, p4_p_ff;
   logic [NE-1:0]                p4_sgn_ff;
   omb_pkg::side_type            p4_side_ff;
   logic                         p4_vld_ff;

   logic [NE-1:0][PW-1:0]        p5_q3_in, p5_q3_ff;
   logic [6:0]                   p5_sh_in, p5_sh_ff;
   logic [NE-1:0]                p5_sgn_ff;
   omb_pkg::side_type            p5_side_ff;
   logic                         p5_vld_ff;

   logic [NE-1:0][PW-1:0]        p6_v;
   logic [NE-1:0]                p6_ovf;
   omb_pkg::res_type             p6_res_in, p6_res_ff;
   logic                         p6_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p1_u_in[k] = omb_pkg::U_W'(((63)'(in_side.nm[k]) * (63)'(inv)) >> 31);
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         p2_t_in[k] = omb_pkg::T_W'(64'(p1_u_ff[omb_pkg::ROW_I[k]])
                                  * 64'(p1_u_ff[omb_pkg::COL_J[k]]));
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         if (omb_pkg::ROW_I[k] == omb_pkg::COL_J[k]) begin
            p3_tt[k]     = p2_t_ff[k] + (omb_pkg::T_W'(1) << 60);
            p3_sgn_in[k] = 1'b0;
         end else begin
            p3_tt[k]     = p2_t_ff[k];
            p3_sgn_in[k] = (p2_side_ff.neg[omb_pkg::ROW_I[k]]
                            != p2_side_ff.neg[omb_pkg::COL_J[k]])
                           && (p2_t_ff[k] != '0);
         end
         p3_t30_in[k] = p3_tt[k][omb_pkg::T_W-1:30];
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         p4_p_in[k] = PW'(p3_t30_ff[k]) * PW'(p3_inv_ff);
      end
   end

   always_comb begin
      for (int k = 0; k < NE; k++) begin
         p5_q3_in[k] = (p4_p_ff[k] >> 2) + ((p4_p_ff[k] >> 2) << 1);
      end
      p5_sh_in = 7'd52 - {p4_side_ff.e[5], p4_side_ff.e};
   end

   always_comb begin
      p6_res_in = '0;
      for (int k = 0; k < NE; k++) begin
         p6_v[k]   = p5_q3_ff[k] >> p5_sh_ff;
         p6_ovf[k] = 1'b0;
         if (p5_sgn_ff[k] && (p6_v[k] != '0)) begin
            if (p6_v[k] > PW'(32'h8000_0000)) begin
               p6_ovf[k] = 1'b1;
               p6_res_in.m[k] = 32'h8000_0000;
            end else begin
               p6_res_in.m[k] = 32'(-p6_v[k]);
            end
         end else begin
            if (p6_v[k] > PW'(32'h7FFF_FFFF)) begin
               p6_ovf[k] = 1'b1;
               p6_res_in.m[k] = 32'h7FFF_FFFF;
            end else begin
               p6_res_in.m[k] = p6_v[k][31:0];
            end
         end
      end
      p6_res_in.overflowed = |p6_ovf;
      if (p5_side_ff.same) begin
         p6_res_in = '0;
         for (int k = 0; k < NE; k++) begin
            if (omb_pkg::ROW_I[k] == omb_pkg::COL_J[k]) begin
               p6_res_in.m[k] = 32'h0100_0000;
            end
         end
      end else if (p5_side_ff.near) begin
         p6_res_in = '0;
         p6_res_in.too_near = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= in_valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_u_ff    <= p1_u_in;
         p1_inv_ff  <= inv;
         p1_side_ff <= in_side;

         p2_t_ff    <= p2_t_in;
         p2_inv_ff  <= p1_inv_ff;
         p2_side_ff <= p1_side_ff;

         p3_t30_ff  <= p3_t30_in;
         p3_sgn_ff  <= p3_sgn_in;
         p3_inv_ff  <= p2_inv_ff;
         p3_side_ff <= p2_side_ff;

         p4_p_ff    <= p4_p_in;
         p4_sgn_ff  <= p3_sgn_ff;
         p4_side_ff <= p3_side_ff;

         p5_q3_ff   <= p5_q3_in;
         p5_sh_ff   <= p5_sh_in;
         p5_sgn_ff  <= p4_sgn_ff;
         p5_side_ff <= p4_side_ff;

         p6_res_ff  <= p6_res_in;
      end
   end

   assign out_valid = p6_vld_ff;
   assign result    = p6_res_ff;

endmodule

// File: rtl/oseen_mobility_block.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility block
// Streams particle pairs into the six entries of their 3x3 mobility block.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while req_ready is high and returns one
// result for every item, in order. Most of the pipeline depth comes from the
// square root and the reciprocal, which each resolve one result bit per
// pipeline stage. An output register and one skid entry sit behind the
// pipeline, so one more item is taken while a result waits; the whole
// pipeline then holds until the skid entry drains.
module oseen_mobility_block (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [omb_pkg::POS_W-1:0] req_a_x,
   input  logic signed [omb_pkg::POS_W-1:0] req_a_y,
   input  logic signed [omb_pkg::POS_W-1:0] req_a_z,
   input  logic signed [omb_pkg::POS_W-1:0] req_b_x,
   input  logic signed [omb_pkg::POS_W-1:0] req_b_y,
   input  logic signed [omb_pkg::POS_W-1:0] req_b_z,
   input  logic                           req_same_particle,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [omb_pkg::ENT_W-1:0] rsp_m_xx,
   output logic signed [omb_pkg::ENT_W-1:0] rsp_m_xy,
   output logic signed [omb_pkg::ENT_W-1:0] rsp_m_xz,
   output logic signed [omb_pkg::ENT_W-1:0] rsp_m_yy,
   output logic signed [omb_pkg::ENT_W-1:0] rsp_m_yz,
   output logic signed [omb_pkg::ENT_W-1:0] rsp_m_zz,
   output logic                           rsp_too_near,
   output logic                           rsp_overflowed,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [2:0]                     csr_paddr,
   input  logic [31:0]                    csr_pwdata,
   output logic [31:0]                    csr_prdata,
   output logic                           csr_pready
);

   logic [31:0] limit_ff;
   logic        en;

   logic                     f_vld;
   logic [omb_pkg::SP_W-1:0] f_sp;
   omb_pkg::side_type        f_side;

   logic                       q_vld;
   logic [omb_pkg::ROOT_W-1:0] q_root;
   omb_pkg::side_type          q_side;

   logic                      d_vld;
   logic [omb_pkg::INV_W-1:0] d_inv;
   omb_pkg::side_type         d_side;

   logic             b_vld;
   omb_pkg::res_type b_res;

   omb_pkg::res_type out_ff, skid_ff;
   logic             out_vld_ff, skid_vld_ff;
   logic             take;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == omb_pkg::ADDR_NEAR_LIMIT) ? limit_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr == omb_pkg::ADDR_NEAR_LIMIT)) begin
         limit_ff <= csr_pwdata;
      end
   end

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   omb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (req_valid),
      .a_x           (req_a_x),
      .a_y           (req_a_y),
      .a_z           (req_a_z),
      .b_x           (req_b_x),
      .b_y           (req_b_y),
      .b_z           (req_b_z),
      .same_particle (req_same_particle),
      .near_limit_sq (limit_ff),
      .out_valid     (f_vld),
      .sp            (f_sp),
      .side          (f_side)
   );

   omb_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_vld),
      .sp        (f_sp),
      .in_side   (f_side),
      .out_valid (q_vld),
      .root      (q_root),
      .out_side  (q_side)
   );

   omb_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_vld),
      .root      (q_root),
      .in_side   (q_side),
      .out_valid (d_vld),
      .inv       (d_inv),
      .out_side  (d_side)
   );

   omb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_vld),
      .inv       (d_inv),
      .in_side   (d_side),
      .out_valid (b_vld),
      .result    (b_res)
   );

   assign take = out_vld_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (en && b_vld) begin
         if (!out_vld_ff || take) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (take) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && b_vld) begin
         if (!out_vld_ff || take) begin
            out_ff <= b_res;
         end else begin
            skid_ff <= b_res;
         end
      end else if (take && skid_vld_ff) begin
         out_ff <= skid_ff;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_m_xx       = out_ff.m[0];
   assign rsp_m_xy       = out_ff.m[1];
   assign rsp_m_xz       = out_ff.m[2];
   assign rsp_m_yy       = out_ff.m[3];
   assign rsp_m_yz       = out_ff.m[4];
   assign rsp_m_zz       = out_ff.m[5];
   assign rsp_too_near   = out_ff.too_near;
   assign rsp_overflowed = out_ff.overflowed;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oseen mobility block testbench
// Streams particle pairs through the block under random handshake pressure and
// compares every result with a bit-exact fixed-point model of the tensor.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic signed [31:0] ax, ay, az, bx, by, bz;
      logic               same;
   } pair_type;

   typedef struct {
      logic [31:0] m [6];
      logic        near;
      logic        ovf;
   } tensor_type;

   localparam int HOLD_LEN = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic req_same_particle = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_m_xx, rsp_m_xy, rsp_m_xz, rsp_m_yy, rsp_m_yz, rsp_m_zz;
   logic rsp_too_near, rsp_overflowed;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   oseen_mobility_block u_dut (.*);

   pair_type   pending_pairs [$];
   tensor_type expected_tensors [$];
   logic [31:0] near_limit = '0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;
   bit      hold_req = 1'b0;
   bit      hold_taken = 1'b0;
   int      mismatches = 0;
   logic    req_ready_seen = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] clamp_entry(input logic [63:0] mag, input logic neg,
                                               inout logic ovf);
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            ovf = 1'b1;
            mag = 64'h8000_0000;
         end
         return 32'(64'd0 - mag);
      end
      if (mag > 64'h7FFF_FFFF) begin
         ovf = 1'b1;
         mag = 64'h7FFF_FFFF;
      end
      return mag[31:0];
   endfunction

   function automatic tensor_type mobility(input pair_type p);
      tensor_type t;
      logic signed [63:0] d;
      logic [63:0] mag [3], nm [3], u [3];
      logic [63:0] mx, sp, s, r, inv, tt, q, v;
      logic neg [3];
      logic sgn;
      int e, i, j, k;
      int ri [6] = '{0, 0, 0, 1, 1, 2};
      int cj [6] = '{0, 1, 2, 1, 2, 2};
      t.near = 1'b0;
      t.ovf = 1'b0;
      if (p.same) begin
         for (k = 0; k < 6; k++) t.m[k] = (ri[k] == cj[k]) ? 32'h0100_0000 : 32'd0;
         return t;
      end
      mx = 0;
      for (k = 0; k < 3; k++) begin
         case (k)
            0: d = 64'(p.ax) - 64'(p.bx);
            1: d = 64'(p.ay) - 64'(p.by);
            default: d = 64'(p.az) - 64'(p.bz);
         endcase
         neg[k] = d < 0;
         mag[k] = neg[k] ? 64'(-d) : 64'(d);
         if (mag[k] > mx) mx = mag[k];
      end
      if (mx < (64'd1 << 16)) begin
         s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
         if (s <= 64'(near_limit)) begin
            for (k = 0; k < 6; k++) t.m[k] = 0;
            t.near = 1'b1;
            return t;
         end
      end
      e = 0;
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         e++;
      end
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1;
         e--;
      end
      sp = 0;
      for (k = 0; k < 3; k++) begin
         nm[k] = (e >= 0) ? (mag[k] << e) : (mag[k] >> (-e));
         sp += nm[k] * nm[k];
      end
      r = int_sqrt(sp);
      inv = (64'd1 << 61) / r;
      for (k = 0; k < 3; k++) u[k] = (nm[k] * inv) >> 31;
      for (k = 0; k < 6; k++) begin
         i = ri[k];
         j = cj[k];
         tt = u[i] * u[j];
         sgn = 1'b0;
         if (i == j) tt += 64'd1 << 60;
         else sgn = (neg[i] != neg[j]) && tt != 0;
         q = ((tt >> 30) * inv) >> 2;
         v = (3 * q) >> (52 - e);
         if (v == 0) sgn = 1'b0;
         t.m[k] = clamp_entry(v, sgn, t.ovf);
      end
      return t;
   endfunction

   function automatic logic signed [31:0] rand_coord(input logic signed [31:0] base);
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return base + $signed(32'($urandom_range(0, 512)) - 32'd256);
         2: return base + $signed(32'($urandom_range(0, 1 << 20)) - 32'(1 << 19));
         3: return base + $signed(32'($urandom_range(0, 1 << 26)) - 32'(1 << 25));
         default: return base + $signed(($urandom >> $urandom_range(0, 31)) ^ 32'h0);
      endcase
   endfunction

   task automatic queue_pair(input logic signed [31:0] ax, ay, az, bx, by, bz,
                             input logic same);
      pair_type p;
      p.ax = ax; p.ay = ay; p.az = az;
      p.bx = bx; p.by = by; p.bz = bz;
      p.same = same;
      pending_pairs = {pending_pairs, p};
   endtask

   task automatic queue_random(input int count);
      logic signed [31:0] ax, ay, az;
      for (int n = 0; n < count; n++) begin
         ax = $urandom;
         ay = $urandom;
         az = $urandom;
         queue_pair(ax, ay, az, rand_coord(ax), rand_coord(ay), rand_coord(az),
                    $urandom_range(0, 9) == 0);
      end
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_valid || expected_tensors.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= omb_pkg::ADDR_NEAR_LIMIT;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      near_limit = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_ready_seen) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               pair_type p;
               p = pending_pairs.pop_front();
               req_a_x <= p.ax; req_a_y <= p.ay; req_a_z <= p.az;
               req_b_x <= p.bx; req_b_y <= p.by; req_b_z <= p.bz;
               req_same_particle <= p.same;
               req_valid <= 1'b1;
               expected_tensors = {expected_tensors, mobility(p)};
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_cycles <= HOLD_LEN;
            rsp_ready <= 1'b0;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= $urandom_range(0, 99) >= recv_idle_pct;
         end
      end
   end

   always @(posedge clock) req_ready_seen <= req_valid && req_ready;

   always @(posedge clock) begin
      tensor_type want;
      logic [31:0] got [6];
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_m_xx, rsp_m_xy, rsp_m_xz, rsp_m_yy, rsp_m_yz, rsp_m_zz};
         if (expected_tensors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item at %0t", $realtime);
         end else begin
            want = expected_tensors.pop_front();
            if (got !== want.m || rsp_too_near !== want.near
                || rsp_overflowed !== want.ovf) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %h %h %h %h %h %h n%b o%b,",
                           want.m[0], want.m[1], want.m[2], want.m[3], want.m[4],
                           want.m[5], want.near, want.ovf,
                           " got %h %h %h %h %h %h n%b o%b",
                           got[0], got[1], got[2], got[3], got[4], got[5],
                           rsp_too_near, rsp_overflowed);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (2) @(posedge clock);
      write_limit(32'd0);
      send_idle_pct = 34;
      recv_idle_pct = 73;
      queue_pair(0, 0, 0, 0, 0, 0, 1'b0);
      queue_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
      queue_pair(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 1'b0);
      queue_pair(32'sh1234, 5, 6, 32'sh1234, 5, 6, 1'b1);
      queue_pair(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, 0, 0, 1'b1);
      queue_pair(1, 0, 0, 0, 0, 0, 1'b0);
      queue_pair(0, 0, 0, 0, 1, 0, 1'b0);
      queue_pair(0, 0, 1, 0, 0, 0, 1'b0);
      queue_pair(32'h10000, 0, 0, 0, 0, 0, 1'b0);
      queue_pair(32'h10000, 32'h10000, 0, 0, 0, 0, 1'b0);
      queue_pair(32'h10000, -32'sh10000, 32'h10000, 0, 0, 0, 1'b0);
      queue_pair(32'hFFFF, 32'hFFFF, 32'hFFFF, 0, 0, 0, 1'b0);
      queue_pair(3, -4, 0, 0, 0, 0, 1'b0);
      queue_pair(32'h100, 0, 0, 0, 0, 0, 1'b0);
      queue_pair(-32'sh5, 7, -9, 2, -3, 4, 1'b0);
      queue_random(600);
      wait_drained();
      write_limit(32'hFFFF_FFFF);
      send_idle_pct = 73;
      recv_idle_pct = 34;
      queue_pair(32'hFFFF, 32'hFFFF, 32'hFFFF, 0, 0, 0, 1'b0);
      queue_pair(32'h10000, 0, 0, 0, 0, 0, 1'b0);
      queue_pair(1, 1, 1, 0, 0, 0, 1'b0);
      queue_random(600);
      wait_drained();
      write_limit(32'd50000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_pair(100, 100, 100, 0, 0, 0, 1'b0);
      queue_pair(200, 0, 0, 0, 0, 0, 1'b0);
      queue_pair(300, 0, 0, 0, 0, 0, 1'b0);
      queue_random(300);
      hold_req = 1'b1;
      wait_drained();
      write_limit($urandom);
      queue_random(430);
      wait_drained();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule

// File: sim.f
rtl/omb_pkg.sv
rtl/omb_front.sv
rtl/omb_sqrt.sv
rtl/omb_recip.sv
rtl/omb_back.sv
rtl/oseen_mobility_block.sv
tb/tb_top.sv
